FILE: rtl/bphr_pkg.sv
package bphr_pkg;

  // Defaults for the top level parameters
  localparam int BUTTON_COUNT = 5;
  localparam int TIME_WIDTH   = 16;

  // Fixed field widths
  localparam int REG_WIDTH   = 16;
  localparam int INDEX_WIDTH = 3;
  localparam int EVENT_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 2;

  // Register reset values
  localparam logic [REG_WIDTH-1:0] POLL_INTERVAL_RESET   = 16'd20;
  localparam logic [REG_WIDTH-1:0] FIRST_DELAY_RESET     = 16'd500;
  localparam logic [REG_WIDTH-1:0] REPEAT_INTERVAL_RESET = 16'd200;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_POLL_INTERVAL   = 2'd0,
    CFG_FIRST_DELAY     = 2'd1,
    CFG_REPEAT_INTERVAL = 2'd2,
    CFG_ENABLE_MASK     = 2'd3
  } cfg_index_t;

  // Button phase; also the event code of a report
  typedef enum logic [EVENT_WIDTH-1:0] {
    PHASE_RELEASED = 2'd0,
    PHASE_PRESSED  = 2'd1,
    PHASE_HELD     = 2'd2
  } phase_t;

  // Decision of the shared step unit for one button
  typedef struct packed {
    phase_t phase;
    logic   report;
    logic   clear;
  } verdict_t;

endpackage

FILE: rtl/bphr_if.sv
interface bphr_tick_if #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT
);
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bphr_report_if;
  logic                             valid;
  logic                             ready;
  logic [bphr_pkg::INDEX_WIDTH-1:0] button_index;
  logic [bphr_pkg::EVENT_WIDTH-1:0] button_event;
  logic                             last_of_poll;

  modport source (output valid, output button_index, output button_event,
                  output last_of_poll, input ready);
  modport sink   (input valid, input button_index, input button_event,
                  input last_of_poll, output ready);
endinterface

FILE: rtl/bphr_step_unit.sv
module bphr_step_unit #(
  parameter int TIME_WIDTH = bphr_pkg::TIME_WIDTH
) (
  input  logic                           active,
  input  logic                           down,
  input  bphr_pkg::phase_t               phase,
  input  logic [TIME_WIDTH-1:0]          elapsed,
  input  logic [bphr_pkg::REG_WIDTH-1:0] first_delay,
  input  logic [bphr_pkg::REG_WIDTH-1:0] repeat_interval,
  output bphr_pkg::verdict_t             verdict,
  output logic [TIME_WIDTH-1:0]          elapsed_next
);

  localparam int CMP_W = (TIME_WIDTH > bphr_pkg::REG_WIDTH) ? TIME_WIDTH
                                                            : bphr_pkg::REG_WIDTH;

  logic [TIME_WIDTH-1:0]          elapsed_inc;
  logic [bphr_pkg::REG_WIDTH-1:0] threshold;
  logic                           reached;

  // Saturating tick count, then one compare against the delay of this phase
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign threshold   = (phase == bphr_pkg::PHASE_HELD) ? repeat_interval : first_delay;
  assign reached     = CMP_W'(elapsed_inc) >= CMP_W'(threshold);

  always_comb begin
    verdict.phase  = phase;
    verdict.report = 1'b0;
    verdict.clear  = 1'b0;
    if (active) begin
      case (phase)
        bphr_pkg::PHASE_RELEASED: begin
          if (down) begin
            verdict.phase  = bphr_pkg::PHASE_PRESSED;
            verdict.report = 1'b1;
            verdict.clear  = 1'b1;
          end
        end
        bphr_pkg::PHASE_PRESSED: begin
          if (down && reached) begin
            verdict.phase  = bphr_pkg::PHASE_HELD;
            verdict.report = 1'b1;
            verdict.clear  = 1'b1;
          end else if (!down) begin
            verdict.phase  = bphr_pkg::PHASE_RELEASED;
            verdict.report = 1'b1;
          end
        end
        bphr_pkg::PHASE_HELD: begin
          if (down && reached) begin
            verdict.report = 1'b1;
            verdict.clear  = 1'b1;
          end else if (!down) begin
            verdict.phase  = bphr_pkg::PHASE_RELEASED;
            verdict.report = 1'b1;
          end
        end
        default: begin
          verdict.phase = phase;
        end
      endcase
    end
  end

  assign elapsed_next = verdict.clear ? '0 : elapsed_inc;

endmodule

FILE: rtl/button_press_hold_repeat.sv
// Channel   Dir  Transaction payload                          Handshake
// tick      in   raw_levels (active-low, one bit per button)  valid/ready
// report    out  button_index, button_event, last_of_poll     valid/ready
// cfg       in   cfg_index, cfg_data                          cfg_we, no wait
//
// A tick passes ST_IDLE, which accepts it and updates the poll counter, then
// ST_SCAN, which steps each button in turn through the shared step unit, then
// ST_FLUSH, which flushes the last report. Only a stalled report channel holds it up.
// Reset (rst, synchronous) restores the register defaults, releases all buttons
// and clears every counter. Reports leave through an output register, so the
// next tick is taken while the final report of a poll still waits.
module button_press_hold_repeat #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT,
  parameter int TIME_WIDTH   = bphr_pkg::TIME_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bphr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [((BUTTON_COUNT > bphr_pkg::REG_WIDTH) ? BUTTON_COUNT
                 : bphr_pkg::REG_WIDTH)-1:0]   cfg_data,
  bphr_tick_if.sink                            tick,
  bphr_report_if.source                        report
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int IW    = bphr_pkg::INDEX_WIDTH;
  localparam int RW    = bphr_pkg::REG_WIDTH;
  localparam int CMP_W = (TIME_WIDTH > RW) ? TIME_WIDTH : RW;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Configuration registers
  logic [RW-1:0]           poll_interval;
  logic [RW-1:0]           first_delay;
  logic [RW-1:0]           repeat_interval;
  logic [BUTTON_COUNT-1:0] enable_mask;

  // Block state
  state_t                  state;
  logic [TIME_WIDTH-1:0]   poll_elapsed;
  bphr_pkg::phase_t        phase   [BUTTON_COUNT];
  logic [TIME_WIDTH-1:0]   elapsed [BUTTON_COUNT];

  // Per-tick working registers
  logic [BUTTON_COUNT-1:0] levels;
  logic                    poll_now;
  logic [IDX_W-1:0]        idx;

  // One report held back until we know whether another follows it
  logic                    pending_valid;
  logic [IDX_W-1:0]        pending_index;
  bphr_pkg::phase_t        pending_event;

  logic [TIME_WIDTH-1:0]   poll_inc;
  logic                    poll_hit;
  bphr_pkg::verdict_t      verdict;
  logic [TIME_WIDTH-1:0]   elapsed_next;
  logic                    out_free;
  logic                    stall;

  assign tick.ready = (state == ST_IDLE);
  assign out_free   = !report.valid || report.ready;

  // Poll counter counts first, then the poll decision sees the new value
  assign poll_inc = (&poll_elapsed) ? poll_elapsed : poll_elapsed + 1'b1;
  assign poll_hit = CMP_W'(poll_inc) >= CMP_W'(poll_interval);

  // The shared per-button unit: saturating count, delay compare, phase step
  bphr_step_unit #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .active          (poll_now && enable_mask[idx]),
    .down            (!levels[idx]),
    .phase           (phase[idx]),
    .elapsed         (elapsed[idx]),
    .first_delay     (first_delay),
    .repeat_interval (repeat_interval),
    .verdict         (verdict),
    .elapsed_next    (elapsed_next)
  );

  // Hold the scan when a new report needs the pending slot and the output
  // register cannot take the one already there
  assign stall = verdict.report && pending_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval   <= bphr_pkg::POLL_INTERVAL_RESET;
      first_delay     <= bphr_pkg::FIRST_DELAY_RESET;
      repeat_interval <= bphr_pkg::REPEAT_INTERVAL_RESET;
      enable_mask     <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        bphr_pkg::CFG_POLL_INTERVAL:   poll_interval   <= cfg_data[RW-1:0];
        bphr_pkg::CFG_FIRST_DELAY:     first_delay     <= cfg_data[RW-1:0];
        bphr_pkg::CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data[RW-1:0];
        bphr_pkg::CFG_ENABLE_MASK:     enable_mask     <= cfg_data[BUTTON_COUNT-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      poll_elapsed  <= '0;
      poll_now      <= 1'b0;
      idx           <= '0;
      pending_valid <= 1'b0;
      report.valid  <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        phase[i]   <= bphr_pkg::PHASE_RELEASED;
        elapsed[i] <= '0;
      end
    end else begin
      // Drop the output transaction once taken; a load below overrides
      if (report.valid && report.ready) begin
        report.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tick.valid) begin
            poll_now     <= poll_hit;
            poll_elapsed <= poll_hit ? '0 : poll_inc;
            idx          <= '0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            phase[idx]   <= verdict.phase;
            elapsed[idx] <= elapsed_next;
            if (verdict.report) begin
              // Earlier report is not the last: push it out unmarked
              if (pending_valid) begin
                report.valid        <= 1'b1;
                report.button_index <= IW'(pending_index);
                report.button_event <= pending_event;
                report.last_of_poll <= 1'b0;
              end
              pending_valid <= 1'b1;
              pending_index <= idx;
              pending_event <= verdict.phase;
            end
            if (idx == LAST_IDX) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          // Final report of the poll goes out marked
          if (!pending_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            report.valid        <= 1'b1;
            report.button_index <= IW'(pending_index);
            report.button_event <= pending_event;
            report.last_of_poll <= 1'b1;
            pending_valid       <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      levels <= tick.raw_levels;
    end
  end

  // No report may linger past the end of a tick
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pending_valid)
    else $error("pending report left while idle");

  // A tick without a poll produces no report
  a_no_poll_no_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !poll_now) |-> !pending_valid && !verdict.report)
    else $error("report on a tick without a poll");

  // Scan index stays on a real button
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= LAST_IDX))
    else $error("scan index beyond last button");

  // Entering flush only happens after the last button was stepped
  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && $past(state) == ST_SCAN) |-> ($past(idx) == LAST_IDX))
    else $error("flush entered before scan finished");

endmodule

FILE: dv/bphr_report_checker.sv
module bphr_report_checker #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT,
  parameter int TIME_WIDTH   = bphr_pkg::TIME_WIDTH,
  parameter int CFG_WIDTH    = (bphr_pkg::BUTTON_COUNT > bphr_pkg::REG_WIDTH)
                               ? bphr_pkg::BUTTON_COUNT : bphr_pkg::REG_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bphr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]                 cfg_data,
  bphr_tick_if                                 tick,
  bphr_report_if                               report,
  output int                                   fail_count,
  output int                                   backlog,
  output int                                   reports_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_WIDTH   = bphr_pkg::REG_WIDTH;
  localparam int INDEX_WIDTH = bphr_pkg::INDEX_WIDTH;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] button;
    bphr_pkg::phase_t       kind;
    logic                   last;
  } key_report_t;

  // Register copies
  logic [REG_WIDTH-1:0]    poll_ms;
  logic [REG_WIDTH-1:0]    first_ms;
  logic [REG_WIDTH-1:0]    repeat_ms;
  logic [BUTTON_COUNT-1:0] enabled;

  // Scanner state
  logic [TIME_WIDTH-1:0] since_poll;
  bphr_pkg::phase_t      phase_of     [BUTTON_COUNT];
  logic [TIME_WIDTH-1:0] since_report [BUTTON_COUNT];

  key_report_t expected_reports[$];
  int          mismatches = 0;
  int          checked    = 0;

  assign fail_count      = mismatches;
  assign reports_checked = checked;

  function automatic logic [TIME_WIDTH-1:0] sat_bump(input logic [TIME_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] report mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic clear_state();
    int i;
    poll_ms    = bphr_pkg::POLL_INTERVAL_RESET;
    first_ms   = bphr_pkg::FIRST_DELAY_RESET;
    repeat_ms  = bphr_pkg::REPEAT_INTERVAL_RESET;
    enabled    = '1;
    since_poll = '0;
    for (i = 0; i < BUTTON_COUNT; i++) begin
      phase_of[i]     = bphr_pkg::PHASE_RELEASED;
      since_report[i] = '0;
    end
    expected_reports.delete();
  endtask

  // Advance one millisecond and queue the reports of a poll, if one is due
  task automatic scan_buttons(input logic [BUTTON_COUNT-1:0] levels);
    key_report_t batch [BUTTON_COUNT];
    int          n;
    int          i;
    logic        fire;
    n = 0;
    since_poll = sat_bump(since_poll);
    for (i = 0; i < BUTTON_COUNT; i++) since_report[i] = sat_bump(since_report[i]);
    if (since_poll < poll_ms) return;
    since_poll = '0;
    for (i = 0; i < BUTTON_COUNT; i++) begin
      fire = 1'b0;
      if (enabled[i]) begin
        if (!levels[i]) begin
          case (phase_of[i])
            bphr_pkg::PHASE_RELEASED: begin
              phase_of[i]     = bphr_pkg::PHASE_PRESSED;
              since_report[i] = '0;
              fire            = 1'b1;
            end
            bphr_pkg::PHASE_PRESSED: begin
              if (since_report[i] >= first_ms) begin
                phase_of[i]     = bphr_pkg::PHASE_HELD;
                since_report[i] = '0;
                fire            = 1'b1;
              end
            end
            bphr_pkg::PHASE_HELD: begin
              if (since_report[i] >= repeat_ms) begin
                since_report[i] = '0;
                fire            = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (phase_of[i] == bphr_pkg::PHASE_PRESSED ||
                     phase_of[i] == bphr_pkg::PHASE_HELD) begin
          phase_of[i] = bphr_pkg::PHASE_RELEASED;
          fire        = 1'b1;
        end
      end
      if (fire) begin
        batch[n].button = INDEX_WIDTH'(i);
        batch[n].kind   = phase_of[i];
        batch[n].last   = 1'b0;
        n++;
      end
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_reports.push_back(batch[i]);
  endtask

  task automatic check_report();
    key_report_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch($sformatf("unexpected report button %0d event %0d last %0d",
                              report.button_index, report.button_event,
                              report.last_of_poll));
      return;
    end
    want = expected_reports.pop_front();
    checked++;
    if (report.button_index !== want.button)
      flag_mismatch($sformatf("button_index %0d, want %0d", report.button_index, want.button));
    if (report.button_event !== want.kind)
      flag_mismatch($sformatf("button %0d event %0d, want %0d", want.button,
                              report.button_event, want.kind));
    if (report.last_of_poll !== want.last)
      flag_mismatch($sformatf("button %0d last_of_poll %0d, want %0d", want.button,
                              report.last_of_poll, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        case (bphr_pkg::cfg_index_t'(cfg_index))
          bphr_pkg::CFG_POLL_INTERVAL:   poll_ms   = cfg_data[REG_WIDTH-1:0];
          bphr_pkg::CFG_FIRST_DELAY:     first_ms  = cfg_data[REG_WIDTH-1:0];
          bphr_pkg::CFG_REPEAT_INTERVAL: repeat_ms = cfg_data[REG_WIDTH-1:0];
          bphr_pkg::CFG_ENABLE_MASK:     enabled   = cfg_data[BUTTON_COUNT-1:0];
          default: ;
        endcase
      end
      if (report.valid && report.ready) check_report();
      if (tick.valid && tick.ready) scan_buttons(tick.raw_levels);
    end
    backlog <= expected_reports.size();
  end

endmodule

FILE: dv/button_press_hold_repeat_test.sv
module button_press_hold_repeat_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT;
  localparam int REG_WIDTH    = bphr_pkg::REG_WIDTH;
  localparam int CFG_WIDTH = (BUTTON_COUNT > REG_WIDTH) ? BUTTON_COUNT : REG_WIDTH;
  // Margin for a tick to finish before touching registers
  localparam int SETTLE_CYCLES   = 16;
  // Long report stall that backs the block up into the tick channel
  localparam int HOLD_OFF_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  bphr_pkg::cfg_index_t   cfg_index;
  logic [CFG_WIDTH-1:0]   cfg_data;

  bphr_tick_if   tick_ch ();
  bphr_report_if report_ch ();

  int  fail_count;
  int  backlog;
  int  reports_checked;
  int  ticks_sent    = 0;
  int  settings_used = 0;
  bit  hold_off_req  = 1'b0;

  // Current "intended" button pattern; random ticks mostly follow it so that
  // buttons stay down long enough to reach the held and repeat phases
  logic [BUTTON_COUNT-1:0] pattern;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_press_hold_repeat u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .report    (report_ch)
  );

  // Watch both channels and the register port, predict, and compare
  bphr_report_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .tick            (tick_ch),
    .report          (report_ch),
    .fail_count      (fail_count),
    .backlog         (backlog),
    .reports_checked (reports_checked)
  );

  // Idle length: mostly none, sometimes short, now and then a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Next tick's levels: mostly the held pattern, sometimes one button toggles,
  // and a few ticks of pure noise that leave the pattern alone
  function automatic logic [BUTTON_COUNT-1:0] next_levels();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return BUTTON_COUNT'($urandom);
    if (r < 30) pattern[$urandom_range(0, BUTTON_COUNT-1)] ^= 1'b1;
    return pattern;
  endfunction

  // Offer one tick transaction and hold it until the block takes it.
  // Drop valid only when a gap precedes the next tick, so valid never gets
  // two assignments in the same step.
  task automatic send_tick(input logic [BUTTON_COUNT-1:0] levels, input bit eager);
    int gap;
    gap = eager ? 0 : idle_len();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.raw_levels <= levels;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  // Stop offering ticks, wait until every predicted report has arrived, then
  // give the block time to finish ticks that cause no report
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last one
  task automatic write_reg(input bphr_pkg::cfg_index_t idx,
                           input logic [CFG_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int poll_ms, input int first_ms, input int rep_ms,
                                input int mask_bits);
    write_reg(bphr_pkg::CFG_POLL_INTERVAL,   CFG_WIDTH'(poll_ms));
    write_reg(bphr_pkg::CFG_FIRST_DELAY,     CFG_WIDTH'(first_ms));
    write_reg(bphr_pkg::CFG_REPEAT_INTERVAL, CFG_WIDTH'(rep_ms));
    write_reg(bphr_pkg::CFG_ENABLE_MASK,     CFG_WIDTH'(mask_bits));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Program one setting, run random ticks under it, then drain.
  // Every 40 ticks the first 10 go out back to back.
  task automatic run_phase(input int poll_ms, input int first_ms, input int rep_ms,
                           input int mask_bits, input int count);
    int k;
    apply_settings(poll_ms, first_ms, rep_ms, mask_bits);
    for (k = 0; k < count; k++) send_tick(next_levels(), (k % 40) < 10);
    settle();
  endtask

  // Report sink: random stalls with some long clean stretches, plus one long
  // hold-off when the stimulus asks for it
  initial begin
    bit held_once;
    int stall;
    int run;
    held_once       = 1'b0;
    report_ch.ready = 1'b0;
    forever begin
      if (hold_off_req && !held_once) begin
        held_once = 1'b1;
        stall     = HOLD_OFF_CYCLES;
      end else begin
        stall = idle_len();
      end
      if (stall > 0) begin
        report_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      report_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = bphr_pkg::CFG_POLL_INTERVAL;
    cfg_data           = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.raw_levels = '1;
    pattern            = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Reset settings: too few ticks for a poll, but the counters advance
    send_tick('1, 1'b0);
    send_tick('0, 1'b0);
    settle();

    // Directed: poll every tick, one-tick first delay, zero repeat interval.
    // Walk all buttons through press, held, repeat with no wait, release,
    // then alternating bits so each pin takes both levels on its own.
    apply_settings(1, 1, 0, 5'b11111);
    send_tick(5'b11111, 1'b0);
    send_tick(5'b00000, 1'b0);
    send_tick(5'b00000, 1'b1);
    send_tick(5'b00000, 1'b0);
    send_tick(5'b11110, 1'b0);
    send_tick(5'b01111, 1'b1);
    send_tick(5'b10101, 1'b0);
    send_tick(5'b01010, 1'b0);
    send_tick(5'b11111, 1'b0);
    settle();

    // Short delays so that held and repeat reports come often
    pattern = '1;
    run_phase(1, 4, 2, 5'b11111, 90);

    // Zero poll interval and zero delays: every tick reports every down button.
    // Ask the sink for its long hold-off here so the block backs up.
    hold_off_req = 1'b1;
    run_phase(0, 0, 0, 5'b11111, 60);

    // Slower poll, partial mask: disabled buttons keep their phase
    run_phase(3, 9, 5, 5'b10101, 70);

    // Delays at the top of the range: press and release only
    run_phase(2, 65535, 65535, 5'b01110, 50);

    // Longest poll interval with nothing enabled: no reports at all
    run_phase(65535, 0, 0, 5'b00000, 15);

    // Back to polling every tick with every button; stale phases resume
    run_phase(1, 2, 0, 5'b11111, 80);

    // Random small settings
    repeat (2) begin
      run_phase($urandom_range(0, 4), $urandom_range(0, 12), $urandom_range(0, 6),
                $urandom_range(0, 31), 50);
    end

    $display("covered %0d ticks under %0d register settings: poll 0..65535, delays 0..65535,",
             ticks_sent, settings_used);
    $display("masks from none to all, one long report stall; %0d reports compared",
             reports_checked);
    if (fail_count == 0 && backlog == 0) begin
      $display("button_press_hold_repeat test passed");
    end else begin
      $display("button_press_hold_repeat test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("button_press_hold_repeat test failed");
    $finish;
  end

endmodule

FILE: button_press_hold_repeat.f
rtl/bphr_pkg.sv
rtl/bphr_if.sv
rtl/bphr_step_unit.sv
rtl/button_press_hold_repeat.sv
dv/bphr_report_checker.sv
dv/button_press_hold_repeat_test.sv
